>>> src/ep2c_pkg.sv
// ----------------------------------------------------------------------------
// ep2c_pkg
// constants and helpers shared by the seconds-to-calendar pipeline
// ----------------------------------------------------------------------------
package ep2c_pkg;

  // days = (secs >> 7) * DAY_RECIP >> DAY_RECIP_SHIFT, exact for 32-bit secs
  localparam int unsigned DAY_PRE_SHIFT   = 7;
  localparam logic [25:0] DAY_RECIP       = 26'd50903317;
  localparam int unsigned DAY_RECIP_SHIFT = 35;
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;

  // the 16-bit day count spans two march-based 100-year cycles; from this day on
  // the later cycle applies and the year gains a century
  localparam logic [15:0] CYCLE_SPLIT_DAY  = 16'd36218;
  localparam logic [15:0] CYCLE_LOW_OFFSET = 16'd306;
  localparam logic [7:0]  CENTURY_STEP     = 8'd100;

  // year within cycle: (4*rem + 3) / 1461
  localparam logic [18:0] YEAR_RECIP       = 19'd367469;
  localparam int unsigned YEAR_RECIP_SHIFT = 29;
  localparam logic [10:0] DAYS_PER_4Y      = 11'd1461;

  // march-based month: (5*doy + 2) / 153
  localparam logic [11:0] MONTH_RECIP       = 12'd3427;
  localparam int unsigned MONTH_RECIP_SHIFT = 19;
  localparam logic [3:0]  MONTH_ROLL        = 4'd10;
  localparam logic [3:0]  MONTH_FWD         = 4'd3;
  localparam logic [3:0]  MONTH_BACK        = 4'd9;

  // time of day
  localparam logic [17:0] HOUR_RECIP       = 18'd149131;
  localparam int unsigned HOUR_RECIP_SHIFT = 29;
  localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;
  localparam logic [12:0] MIN_RECIP        = 13'd4370;
  localparam int unsigned MIN_RECIP_SHIFT  = 18;
  localparam logic [5:0]  SECS_PER_MIN     = 6'd60;

  // first day-of-year of each march-based month, (153*mm + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mm);
    logic [8:0] start;
    case (mm)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

>>> src/ep2c_if.sv
// ----------------------------------------------------------------------------
// ep2c channel interfaces
// valid/ready channels for timestamps in and calendar results out
// ----------------------------------------------------------------------------
interface ep2c_sec_if;
  logic        valid;
  logic        ready;
  logic [31:0] seconds_since_epoch;

  modport source (output valid, output seconds_since_epoch, input ready);
  modport sink   (input valid, input seconds_since_epoch, output ready);
endinterface

interface ep2c_cal_if;
  logic       valid;
  logic       ready;
  logic [7:0] year_offset;
  logic [3:0] month_number;
  logic [4:0] day_of_month;
  logic [4:0] hour_of_day;
  logic [5:0] minute_of_hour;
  logic [5:0] second_of_minute;

  modport source (output valid, output year_offset, output month_number,
                  output day_of_month, output hour_of_day, output minute_of_hour,
                  output second_of_minute, input ready);
  modport sink   (input valid, input year_offset, input month_number,
                  input day_of_month, input hour_of_day, input minute_of_hour,
                  input second_of_minute, output ready);
endinterface

>>> src/ep2c_day_split.sv
// ----------------------------------------------------------------------------
// ep2c_day_split
// splits seconds into day count and time of day, picks the 100-year cycle
// ----------------------------------------------------------------------------
module ep2c_day_split (
  input  logic        clk,
  input  logic        adv,
  input  logic [31:0] secs,
  output logic [15:0] rem,
  output logic        cent,
  output logic [16:0] tod
);

  logic [50:0] day_prod;
  logic [15:0] days;
  logic [31:0] secs_d;
  logic [32:0] day_secs;
  logic [32:0] tod_full;

  // stage 1: day count by reciprocal
  assign day_prod = 51'(secs[31:ep2c_pkg::DAY_PRE_SHIFT]) * 51'(ep2c_pkg::DAY_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      days   <= day_prod[ep2c_pkg::DAY_RECIP_SHIFT +: 16];
      secs_d <= secs;
    end
  end

  // stage 2: remainder seconds and day within the cycle
  assign day_secs = 33'(days) * 33'(ep2c_pkg::SECS_PER_DAY);
  assign tod_full = {1'b0, secs_d} - day_secs;

  always_ff @(posedge clk) begin
    if (adv) begin
      tod <= tod_full[16:0];
      if (days >= ep2c_pkg::CYCLE_SPLIT_DAY) begin
        rem  <= days - ep2c_pkg::CYCLE_SPLIT_DAY;
        cent <= 1'b1;
      end else begin
        rem  <= days + ep2c_pkg::CYCLE_LOW_OFFSET;
        cent <= 1'b0;
      end
    end
  end

endmodule

>>> src/ep2c_date_path.sv
// ----------------------------------------------------------------------------
// ep2c_date_path
// year, month and day from the day within the 100-year cycle
// ----------------------------------------------------------------------------
module ep2c_date_path (
  input  logic        clk,
  input  logic        adv,
  input  logic [15:0] rem,
  input  logic        cent,
  output logic [7:0]  year_offset,
  output logic [3:0]  month_number,
  output logic [4:0]  day_of_month
);

  logic [17:0] yr_num;
  logic [36:0] yr_prod;
  logic [6:0]  yr3;
  logic [15:0] rem3;
  logic        cent3;

  logic [17:0] yr_days;
  logic [15:0] doy_full;
  logic [8:0]  doy4;
  logic [6:0]  yr4;
  logic        cent4;

  logic [10:0] mm_num;
  logic [22:0] mm_prod;
  logic [3:0]  mm5;
  logic [8:0]  doy5;
  logic [6:0]  yr5;
  logic        cent5;

  logic [8:0]  day_full;
  logic        roll;

  // stage 3: year within the cycle
  assign yr_num  = {rem, 2'b11};
  assign yr_prod = 37'(yr_num) * 37'(ep2c_pkg::YEAR_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      yr3   <= yr_prod[ep2c_pkg::YEAR_RECIP_SHIFT +: 7];
      rem3  <= rem;
      cent3 <= cent;
    end
  end

  // stage 4: day of the march-based year
  assign yr_days  = 18'(yr3) * 18'(ep2c_pkg::DAYS_PER_4Y);
  assign doy_full = rem3 - yr_days[17:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      doy4  <= doy_full[8:0];
      yr4   <= yr3;
      cent4 <= cent3;
    end
  end

  // stage 5: march-based month
  assign mm_num  = 11'({doy4, 2'b00}) + 11'(doy4) + 11'd2;
  assign mm_prod = 23'(mm_num) * 23'(ep2c_pkg::MONTH_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      mm5   <= mm_prod[ep2c_pkg::MONTH_RECIP_SHIFT +: 4];
      doy5  <= doy4;
      yr5   <= yr4;
      cent5 <= cent4;
    end
  end

  // stage 6: calendar fields, january and february belong to the next year
  assign roll     = (mm5 >= ep2c_pkg::MONTH_ROLL);
  assign day_full = doy5 - ep2c_pkg::month_start(mm5) + 9'd1;

  always_ff @(posedge clk) begin
    if (adv) begin
      day_of_month <= day_full[4:0];
      month_number <= roll ? (mm5 - ep2c_pkg::MONTH_BACK) : (mm5 + ep2c_pkg::MONTH_FWD);
      year_offset  <= (cent5 ? ep2c_pkg::CENTURY_STEP : 8'd0) + 8'(yr5) + 8'(roll);
    end
  end

endmodule

>>> src/ep2c_time_path.sv
// ----------------------------------------------------------------------------
// ep2c_time_path
// hour, minute and second from the seconds within the day
// ----------------------------------------------------------------------------
module ep2c_time_path (
  input  logic        clk,
  input  logic        adv,
  input  logic [16:0] tod,
  output logic [4:0]  hour_of_day,
  output logic [5:0]  minute_of_hour,
  output logic [5:0]  second_of_minute
);

  logic [34:0] hour_prod;
  logic [4:0]  hour3;
  logic [16:0] tod3;

  logic [16:0] hour_secs;
  logic [16:0] todh_full;
  logic [11:0] todh4;
  logic [4:0]  hour4;

  logic [24:0] min_prod;
  logic [5:0]  min5;
  logic [11:0] todh5;
  logic [4:0]  hour5;

  logic [11:0] min_secs;
  logic [11:0] sec_full;

  // stage 3: hour
  assign hour_prod = 35'(tod) * 35'(ep2c_pkg::HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      hour3 <= hour_prod[ep2c_pkg::HOUR_RECIP_SHIFT +: 5];
      tod3  <= tod;
    end
  end

  // stage 4: seconds within the hour
  assign hour_secs = 17'(hour3) * 17'(ep2c_pkg::SECS_PER_HOUR);
  assign todh_full = tod3 - hour_secs;

  always_ff @(posedge clk) begin
    if (adv) begin
      todh4 <= todh_full[11:0];
      hour4 <= hour3;
    end
  end

  // stage 5: minute
  assign min_prod = 25'(todh4) * 25'(ep2c_pkg::MIN_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      min5  <= min_prod[ep2c_pkg::MIN_RECIP_SHIFT +: 6];
      todh5 <= todh4;
      hour5 <= hour4;
    end
  end

  // stage 6: second and output fields
  assign min_secs = 12'(min5) * 12'(ep2c_pkg::SECS_PER_MIN);
  assign sec_full = todh5 - min_secs;

  always_ff @(posedge clk) begin
    if (adv) begin
      hour_of_day      <= hour5;
      minute_of_hour   <= min5;
      second_of_minute <= sec_full[5:0];
    end
  end

endmodule

>>> src/epoch_seconds_to_calendar.sv
// a timestamp beat taken into the input register passes stages 1 to 5 and is offered from the output register
// throughput: one beat per cycle; the seven-stage pipeline moves as one and holds
//   only while the output register is full and not taken
// reset: clears the stage valid flags, so the pipeline comes up empty; data
//   registers are left alone
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// converts seconds since 2001-01-01 00:00:00 into a gregorian date and time
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar (
  input  logic              clk,
  input  logic              rst,
  ep2c_sec_if.sink          stamp,
  ep2c_cal_if.source        calendar
);

  // stage 0 input register, stages 1..5 working, stage 6 output register
  localparam int unsigned STAGES = 7;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] vld_next;
  logic              adv;
  logic [31:0]       secs;
  logic [15:0]       rem;
  logic              cent;
  logic [16:0]       tod;

  // the whole pipeline steps together; a bubble in the output register or a
  // taken output beat lets every stage move on
  assign adv         = !vld[STAGES-1] || calendar.ready;
  assign stamp.ready = adv;

  always_comb begin
    vld_next = vld;
    if (adv) begin
      vld_next = {vld[STAGES-2:0], stamp.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  // input register, loads only on a moving pipeline
  always_ff @(posedge clk) begin
    if (adv) begin
      secs <= stamp.seconds_since_epoch;
    end
  end

  // stages 1 and 2: day count, time of day and 100-year cycle
  ep2c_day_split u_day_split (
    .clk  (clk),
    .adv  (adv),
    .secs (secs),
    .rem  (rem),
    .cent (cent),
    .tod  (tod)
  );

  // stages 3 to 6: year, month and day
  ep2c_date_path u_date_path (
    .clk          (clk),
    .adv          (adv),
    .rem          (rem),
    .cent         (cent),
    .year_offset  (calendar.year_offset),
    .month_number (calendar.month_number),
    .day_of_month (calendar.day_of_month)
  );

  // stages 3 to 6 in parallel: hour, minute and second
  ep2c_time_path u_time_path (
    .clk              (clk),
    .adv              (adv),
    .tod              (tod),
    .hour_of_day      (calendar.hour_of_day),
    .minute_of_hour   (calendar.minute_of_hour),
    .second_of_minute (calendar.second_of_minute)
  );

  assign calendar.valid = vld[STAGES-1];

endmodule
